[rtl/core/srdb_pkg.sv]
// Shared constants, control-word types and the sequencer program of the
// SATA read descriptor builder. No dependencies.
package srdb_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int CHUNK_BYTES  = 32768;
    localparam int SLOT_COUNT   = 32;

    localparam int SECTOR_LOG2  = 9;
    localparam int CHUNK_LOG2   = $clog2(CHUNK_BYTES);
    localparam int LIMIT_BYTES  = MAX_ENTRIES * CHUNK_BYTES;
    localparam int LIMIT_SECTORS = LIMIT_BYTES / 512;

    localparam int SECTOR_W = 48;
    localparam int WANT_W   = 16;
    localparam int ADDR_W   = 64;
    localparam int BUSY_W   = 32;
    localparam int SLOT_W   = 5;
    localparam int CNT_W    = 11;
    localparam int TOT_W    = 5;
    localparam int NUM_W    = 4;
    localparam int LEN_W    = 15;

    localparam int BYTES_W  = WANT_W + SECTOR_LOG2;
    localparam int ENT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PC_W     = 2;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [1:0] {
        COND_NONE = 2'd0,
        COND_IN   = 2'd1,
        COND_OUT  = 2'd2
    } t_cond;

    typedef struct packed {
        logic  in_ready;
        logic  decode;
        logic  emit;
        logic  kind;
        t_cond cond;
        t_pc   t_more;
        t_pc   t_done;
    } t_ctrl;

    localparam t_pc PC_WAIT   = 2'd0;
    localparam t_pc PC_DECODE = 2'd1;
    localparam t_pc PC_HEADER = 2'd2;
    localparam t_pc PC_DESC   = 2'd3;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DESC   = 1'b1;

    function automatic t_ctrl rom_word(input t_pc pc);
        t_ctrl w;
        w = '0;
        unique case (pc)
            PC_WAIT: begin
                w.in_ready = 1'b1;
                w.cond     = COND_IN;
                w.t_more   = PC_DECODE;
                w.t_done   = PC_DECODE;
            end
            PC_DECODE: begin
                w.decode = 1'b1;
                w.cond   = COND_NONE;
                w.t_more = PC_HEADER;
                w.t_done = PC_HEADER;
            end
            PC_HEADER: begin
                w.emit   = 1'b1;
                w.kind   = KIND_HEADER;
                w.cond   = COND_OUT;
                w.t_more = PC_DESC;
                w.t_done = PC_WAIT;
            end
            PC_DESC: begin
                w.emit   = 1'b1;
                w.kind   = KIND_DESC;
                w.cond   = COND_OUT;
                w.t_more = PC_DESC;
                w.t_done = PC_WAIT;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

[rtl/core/sata_read_descriptor_builder.sv]
// Top level of the SATA read descriptor builder: microcoded sequencer and
// datapath. Depends on srdb_pkg.
//
// One read request turns into a command header result followed by up to
// MAX_ENTRIES descriptor results, one result per cycle while the sink is
// ready. A request passes through the accept, decode and header steps, then
// one descriptor step per descriptor; the four-step program in the control
// ROM handles one request at a time, and the next request is taken the cycle
// after the last result.
module sata_read_descriptor_builder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [srdb_pkg::SECTOR_W-1:0]  i_start_sector,
    input  logic [srdb_pkg::WANT_W-1:0]    i_sectors_wanted,
    input  logic [srdb_pkg::ADDR_W-1:0]    i_buffer_base,
    input  logic [srdb_pkg::BUSY_W-1:0]    i_busy_slots,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_item_kind,
    output logic                           o_no_free_slot,
    output logic [srdb_pkg::SLOT_W-1:0]    o_chosen_slot,
    output logic [srdb_pkg::SECTOR_W-1:0]  o_command_sector,
    output logic [srdb_pkg::CNT_W-1:0]     o_command_count,
    output logic [srdb_pkg::TOT_W-1:0]     o_entry_total,
    output logic [srdb_pkg::NUM_W-1:0]     o_entry_number,
    output logic [srdb_pkg::ADDR_W-1:0]    o_entry_address,
    output logic [srdb_pkg::LEN_W-1:0]     o_entry_length_less_one,
    output logic                           o_last_item
);

    srdb_pkg::t_pc   r_pc, n_pc;
    srdb_pkg::t_ctrl w_ctrl;

    logic [srdb_pkg::SECTOR_W-1:0] r_sector;
    logic [srdb_pkg::WANT_W-1:0]   r_want;
    logic [srdb_pkg::ADDR_W-1:0]   r_addr;
    logic [srdb_pkg::BUSY_W-1:0]   r_busy;
    logic                          r_noslot;
    logic [srdb_pkg::SLOT_W-1:0]   r_slot;
    logic [srdb_pkg::WANT_W-1:0]   r_count;
    logic [srdb_pkg::ENT_W-1:0]    r_entries;
    logic [srdb_pkg::BYTES_W-1:0]  r_rest;
    logic [srdb_pkg::IDX_W-1:0]    r_idx;

    logic                          w_found;
    logic [srdb_pkg::SLOT_W-1:0]   w_slot;
    logic [srdb_pkg::WANT_W-1:0]   w_count;
    logic [srdb_pkg::BYTES_W-1:0]  w_bytes;
    logic [srdb_pkg::BYTES_W:0]    w_round;
    logic [srdb_pkg::ENT_W-1:0]    w_entries;
    logic [srdb_pkg::BYTES_W-1:0]  w_len;
    logic [srdb_pkg::BYTES_W-1:0]  w_len_m1;
    logic                          w_desc_last;
    logic                          w_last;
    logic                          w_in_acc;
    logic                          w_out_acc;

    assign w_ctrl    = srdb_pkg::rom_word(r_pc);
    assign w_in_acc  = i_in_valid && w_ctrl.in_ready;
    assign w_out_acc = w_ctrl.emit && i_out_ready;

    always_comb begin
        w_found = 1'b0;
        w_slot  = '0;
        for (int s = srdb_pkg::SLOT_COUNT - 1; s >= 0; s--) begin
            if (!r_busy[s]) begin
                w_found = 1'b1;
                w_slot  = srdb_pkg::SLOT_W'(s);
            end
        end
    end

    always_comb begin
        if (32'(r_want) > srdb_pkg::LIMIT_SECTORS) begin
            w_count = srdb_pkg::WANT_W'(srdb_pkg::LIMIT_SECTORS);
        end else begin
            w_count = r_want;
        end
        w_bytes   = {w_count, {srdb_pkg::SECTOR_LOG2{1'b0}}};
        w_round   = {1'b0, w_bytes} + (srdb_pkg::BYTES_W + 1)'(srdb_pkg::CHUNK_BYTES - 1);
        w_entries = srdb_pkg::ENT_W'(w_round >> srdb_pkg::CHUNK_LOG2);
    end

    always_comb begin
        if (r_rest < srdb_pkg::BYTES_W'(srdb_pkg::CHUNK_BYTES)) begin
            w_len = r_rest;
        end else begin
            w_len = srdb_pkg::BYTES_W'(srdb_pkg::CHUNK_BYTES);
        end
        w_len_m1    = w_len - srdb_pkg::BYTES_W'(1);
        w_desc_last = (srdb_pkg::ENT_W'(r_idx) + srdb_pkg::ENT_W'(1)) == r_entries;
        if (w_ctrl.kind == srdb_pkg::KIND_DESC) begin
            w_last = w_desc_last;
        end else begin
            w_last = r_noslot || (r_entries == '0);
        end
    end

    always_comb begin
        n_pc = r_pc;
        unique case (w_ctrl.cond)
            srdb_pkg::COND_NONE: n_pc = w_ctrl.t_more;
            srdb_pkg::COND_IN: begin
                if (w_in_acc) n_pc = w_ctrl.t_more;
            end
            srdb_pkg::COND_OUT: begin
                if (w_out_acc) n_pc = w_last ? w_ctrl.t_done : w_ctrl.t_more;
            end
            default: n_pc = srdb_pkg::PC_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= srdb_pkg::PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sector <= i_start_sector;
            r_want   <= i_sectors_wanted;
            r_addr   <= i_buffer_base;
            r_busy   <= i_busy_slots;
        end
        if (w_ctrl.decode) begin
            r_noslot  <= !w_found;
            r_slot    <= w_slot;
            r_count   <= w_found ? w_count : '0;
            r_entries <= w_found ? w_entries : '0;
            r_rest    <= w_bytes;
            r_idx     <= '0;
        end
        if (w_out_acc && w_ctrl.kind == srdb_pkg::KIND_DESC) begin
            r_idx  <= r_idx + srdb_pkg::IDX_W'(1);
            r_addr <= r_addr + srdb_pkg::ADDR_W'(srdb_pkg::CHUNK_BYTES);
            r_rest <= r_rest - srdb_pkg::BYTES_W'(srdb_pkg::CHUNK_BYTES);
        end
    end

    always_comb begin
        o_in_ready              = w_ctrl.in_ready;
        o_out_valid             = w_ctrl.emit;
        o_item_kind             = w_ctrl.kind;
        o_last_item             = w_last;
        o_no_free_slot          = '0;
        o_chosen_slot           = r_noslot ? '0 : r_slot;
        o_command_sector        = '0;
        o_command_count         = '0;
        o_entry_total           = '0;
        o_entry_number          = '0;
        o_entry_address         = '0;
        o_entry_length_less_one = '0;
        if (w_ctrl.kind == srdb_pkg::KIND_DESC) begin
            o_entry_number          = srdb_pkg::NUM_W'(r_idx);
            o_entry_address         = r_addr;
            o_entry_length_less_one = srdb_pkg::LEN_W'(w_len_m1);
        end else begin
            o_no_free_slot   = r_noslot;
            o_command_sector = r_noslot ? '0 : r_sector;
            o_command_count  = srdb_pkg::CNT_W'(r_count);
            o_entry_total    = srdb_pkg::TOT_W'(r_entries);
        end
    end

endmodule
